>>> src/q2e_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// q2e_pkg
// Shared widths, constants and the arctangent table for the quaternion to
// Euler angle pipeline.
// ----------------------------------------------------------------------------
package q2e_pkg;

    localparam int IN_W     = 16;
    localparam int ANG_W    = 16;
    localparam int PITCH_W  = 15;
    localparam int ARG_W    = 34;   // atan2 arguments, Q.28 with headroom
    localparam int XW       = 44;   // CORDIC vector width after normalizing
    localparam int ZW       = 34;   // CORDIC angle, Q2.30
    localparam int RND_W    = 18;   // angle rounded to Q3.13 before limiting
    localparam int NORM_EXP = 40;   // vectors are scaled up to 2^40
    localparam int TBL_N    = 24;

    localparam int SQ_STAGES = 29;  // result bits of the square root
    localparam int SQ_IN_W   = 2 * SQ_STAGES;
    localparam int REM_W     = 32;

    localparam logic signed [ARG_W-1:0] ONE_Q28 = ARG_W'(64'sd268435456);
    localparam logic signed [ZW-1:0]    PI_Q30  = ZW'(64'sd3373259426);
    localparam logic signed [RND_W-1:0] LIM_PI     = RND_W'(25736);
    localparam logic signed [RND_W-1:0] LIM_HALFPI = RND_W'(12868);

    localparam logic [31:0] ATAN_TABLE [0:TBL_N-1] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
        32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
        32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
        32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
        32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
    };

    typedef struct packed {
        logic signed [ARG_W-1:0] num_r;
        logic signed [ARG_W-1:0] den_r;
        logic signed [ARG_W-1:0] num_y;
        logic signed [ARG_W-1:0] den_y;
        logic signed [ARG_W-1:0] s;
    } t_args;

endpackage

`default_nettype wire

>>> src/q2e_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// q2e_sqrt
// Pipelined restoring integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module q2e_sqrt
    import q2e_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic [SQ_IN_W-1:0]   i_v,
    output logic      [SQ_STAGES-1:0] o_root
);

    logic [REM_W-1:0]     r_rem  [0:SQ_STAGES-1];
    logic [SQ_STAGES-1:0] r_root [0:SQ_STAGES-1];
    logic [SQ_IN_W-1:0]   r_v    [0:SQ_STAGES-1];

    genvar k;
    generate
        for (k = 0; k < SQ_STAGES; k++) begin : g_stage
            logic [REM_W-1:0]     p_rem;
            logic [SQ_STAGES-1:0] p_root;
            logic [SQ_IN_W-1:0]   p_v;
            logic [REM_W-1:0]     rem_sh;
            logic [REM_W-1:0]     trial;
            logic                 ge;

            if (k == 0) begin : g_first
                assign p_rem  = '0;
                assign p_root = '0;
                assign p_v    = i_v;
            end else begin : g_next
                assign p_rem  = r_rem[k-1];
                assign p_root = r_root[k-1];
                assign p_v    = r_v[k-1];
            end

            // Bring down the next two bits and try to set the next root bit.
            assign rem_sh = {p_rem[REM_W-3:0], p_v[SQ_IN_W-1-2*k -: 2]};
            assign trial  = REM_W'({p_root, 2'b01});
            assign ge     = (rem_sh >= trial);

            always_ff @(posedge i_clk) begin
                r_rem[k]  <= ge ? (rem_sh - trial) : rem_sh;
                r_root[k] <= {p_root[SQ_STAGES-2:0], ge};
                r_v[k]    <= p_v;
            end
        end
    endgenerate

    assign o_root = r_root[SQ_STAGES-1];

endmodule

`default_nettype wire

>>> src/q2e_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// q2e_cordic
// Pipelined vectoring CORDIC atan2 with half-plane fold and normalization,
// giving the angle rounded to Q3.13 (not yet limited).
// ----------------------------------------------------------------------------
module q2e_cordic
    import q2e_pkg::*;
#(
    parameter int P_ITER = 16
) (
    input  wire logic                    i_clk,
    input  wire logic signed [ARG_W-1:0] i_y,
    input  wire logic signed [ARG_W-1:0] i_x,
    output logic signed      [RND_W-1:0] o_angle
);

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic        [XW-1:0] m;
    } t_norm;

    typedef struct packed {
        logic signed [ZW-1:0] z;
        logic                 spec;
        logic                 spec_pi;
    } t_side;

    function automatic t_norm norm_step(input t_norm a, input int sh);
        t_norm r;
        r = a;
        if ((a.m >> (NORM_EXP - sh)) == '0) begin
            r.x = a.x <<< sh;
            r.y = a.y <<< sh;
            r.m = a.m << sh;
        end
        return r;
    endfunction

    // Fold into the right half-plane.
    logic signed [XW-1:0] xe, ye, xn, yn;
    logic        [XW-1:0] ax, ay;
    t_norm                p_norm;
    t_side                p_side;

    always_comb begin
        xe = XW'(i_x);
        ye = XW'(i_y);
        xn = i_x[ARG_W-1] ? -xe : xe;
        yn = i_x[ARG_W-1] ? -ye : ye;
        ax = xn[XW-1] ? XW'(-xn) : XW'(xn);
        ay = yn[XW-1] ? XW'(-yn) : XW'(yn);
        p_norm.x = xn;
        p_norm.y = yn;
        p_norm.m = (ax > ay) ? ax : ay;
        p_side.spec    = (i_y == '0);
        p_side.spec_pi = i_x[ARG_W-1];
        if (i_x[ARG_W-1]) begin
            p_side.z = (i_y > 0) ? PI_Q30 : -PI_Q30;
        end else begin
            p_side.z = '0;
        end
    end

    t_norm r_pn, r_n1, r_n2;
    t_side r_ps, r_n1s, r_n2s;

    logic signed [XW-1:0] r_x   [0:P_ITER];
    logic signed [XW-1:0] r_y   [0:P_ITER];
    logic signed [ZW-1:0] r_z   [0:P_ITER];
    logic                 r_sp  [0:P_ITER];
    logic                 r_spi [0:P_ITER];

    t_norm n_n3;

    // The greedy shifts find the largest scale that stays below 2^40; the
    // final single shift then lifts the larger magnitude to 2^40 or above.
    always_comb begin
        n_n3   = norm_step(norm_step(r_n2, 2), 1);
        n_n3.x = n_n3.x <<< 1;
        n_n3.y = n_n3.y <<< 1;
        n_n3.m = n_n3.m << 1;
    end

    always_ff @(posedge i_clk) begin
        r_pn     <= p_norm;
        r_ps     <= p_side;
        r_n1     <= norm_step(norm_step(r_pn, 32), 16);
        r_n1s    <= r_ps;
        r_n2     <= norm_step(norm_step(r_n1, 8), 4);
        r_n2s    <= r_n1s;
        r_x[0]   <= n_n3.x;
        r_y[0]   <= n_n3.y;
        r_z[0]   <= r_n2s.z;
        r_sp[0]  <= r_n2s.spec;
        r_spi[0] <= r_n2s.spec_pi;
    end

    genvar i;
    generate
        for (i = 0; i < P_ITER; i++) begin : g_iter
            logic signed [XW-1:0] n_x, n_y;
            logic signed [ZW-1:0] n_z, ang;

            assign ang = signed'(ZW'(ATAN_TABLE[i]));

            always_comb begin
                if (!r_y[i][XW-1]) begin
                    n_x = r_x[i] + (r_y[i] >>> i);
                    n_y = r_y[i] - (r_x[i] >>> i);
                    n_z = r_z[i] + ang;
                end else begin
                    n_x = r_x[i] - (r_y[i] >>> i);
                    n_y = r_y[i] + (r_x[i] >>> i);
                    n_z = r_z[i] - ang;
                end
            end

            always_ff @(posedge i_clk) begin
                r_x[i+1]   <= n_x;
                r_y[i+1]   <= n_y;
                r_z[i+1]   <= n_z;
                r_sp[i+1]  <= r_sp[i];
                r_spi[i+1] <= r_spi[i];
            end
        end
    endgenerate

    // A vector on the x axis skips the iterations: 0, or pi on the negative side.
    logic signed [ZW-1:0] zf;
    logic signed [ZW:0]   zr;

    always_comb begin
        if (r_sp[P_ITER]) begin
            zf = r_spi[P_ITER] ? PI_Q30 : '0;
        end else begin
            zf = r_z[P_ITER];
        end
        zr = (ZW+1)'(zf) + (ZW+1)'(65536);
    end

    always_ff @(posedge i_clk) begin
        o_angle <= RND_W'(zr >>> 17);
    end

endmodule

`default_nettype wire

>>> src/quaternion_to_euler_angles.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// ZYX roll, pitch and yaw from a Q1.14 quaternion, as Q3.13 radians.
// ----------------------------------------------------------------------------
// The block takes one quaternion in every clock cycle (start while busy is
// low) and delivers its angles marked by a one-cycle o_valid strobe;
// results come out in input order and must be taken when shown, since
// there is no hold-off on the output side. The latency is set by the
// 29-stage square root on the pitch path, followed by one stage per CORDIC
// iteration; busy is high only right after reset.
module quaternion_to_euler_angles
    import q2e_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic signed [IN_W-1:0]    i_quat_w,
    input  wire logic signed [IN_W-1:0]    i_quat_x,
    input  wire logic signed [IN_W-1:0]    i_quat_y,
    input  wire logic signed [IN_W-1:0]    i_quat_z,
    output logic                           o_valid,
    output logic signed [ANG_W-1:0]        o_roll_angle,
    output logic signed [PITCH_W-1:0]      o_pitch_angle,
    output logic signed [ANG_W-1:0]        o_yaw_angle
);

    localparam int DLY = SQ_STAGES + 2;
    localparam int LAT = CORDIC_ITERATIONS + 40;

    logic w_accept;
    logic r_busy;
    logic [LAT-1:0] r_vld;

    assign w_accept = start && !r_busy;
    assign busy     = r_busy;
    assign o_valid  = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_vld  <= '0;
        end else begin
            r_busy <= 1'b0;
            r_vld  <= {r_vld[LAT-2:0], w_accept};
        end
    end

    // Input register and products.
    logic signed [IN_W-1:0] r_w, r_x, r_y, r_z;
    logic signed [31:0] r_wx, r_yz, r_xx, r_yy, r_wy, r_zx, r_wz, r_xy, r_zz;

    always_ff @(posedge i_clk) begin
        r_w  <= i_quat_w;
        r_x  <= i_quat_x;
        r_y  <= i_quat_y;
        r_z  <= i_quat_z;
        r_wx <= r_w * r_x;
        r_yz <= r_y * r_z;
        r_xx <= r_x * r_x;
        r_yy <= r_y * r_y;
        r_wy <= r_w * r_y;
        r_zx <= r_z * r_x;
        r_wz <= r_w * r_z;
        r_xy <= r_x * r_y;
        r_zz <= r_z * r_z;
    end

    // atan2 arguments and the clamped arcsine argument.
    t_args n_args, r_args;
    logic signed [ARG_W-1:0] s_raw;

    always_comb begin
        n_args.num_r = (ARG_W'(r_wx) + ARG_W'(r_yz)) <<< 1;
        n_args.den_r = ONE_Q28 - ((ARG_W'(r_xx) + ARG_W'(r_yy)) <<< 1);
        n_args.num_y = (ARG_W'(r_wz) + ARG_W'(r_xy)) <<< 1;
        n_args.den_y = ONE_Q28 - ((ARG_W'(r_yy) + ARG_W'(r_zz)) <<< 1);
        s_raw        = (ARG_W'(r_wy) - ARG_W'(r_zx)) <<< 1;
        if (s_raw > ONE_Q28) begin
            n_args.s = ONE_Q28;
        end else if (s_raw < -ONE_Q28) begin
            n_args.s = -ONE_Q28;
        end else begin
            n_args.s = s_raw;
        end
    end

    logic signed [29:0] w_s30;
    logic signed [59:0] w_ss;
    logic [56:0] r_ss;
    logic [56:0] r_v;

    assign w_s30 = r_args.s[29:0];
    assign w_ss  = w_s30 * w_s30;

    always_ff @(posedge i_clk) begin
        r_args <= n_args;
        r_ss   <= w_ss[56:0];
        r_v    <= {1'b1, 56'd0} - r_ss;
    end

    logic [SQ_STAGES-1:0] w_root;

    q2e_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_v    ({1'b0, r_v}),
        .o_root (w_root)
    );

    // Hold the other arguments until the root is ready.
    t_args r_dly [0:DLY-1];

    always_ff @(posedge i_clk) begin
        r_dly[0] <= r_args;
        for (int j = 1; j < DLY; j++) begin
            r_dly[j] <= r_dly[j-1];
        end
    end

    logic signed [ARG_W-1:0] w_cos;
    logic signed [RND_W-1:0] w_roll, w_pitch, w_yaw;

    assign w_cos = signed'(ARG_W'(w_root));

    q2e_cordic #(.P_ITER(CORDIC_ITERATIONS)) u_roll (
        .i_clk   (i_clk),
        .i_y     (r_dly[DLY-1].num_r),
        .i_x     (r_dly[DLY-1].den_r),
        .o_angle (w_roll)
    );

    q2e_cordic #(.P_ITER(CORDIC_ITERATIONS)) u_pitch (
        .i_clk   (i_clk),
        .i_y     (r_dly[DLY-1].s),
        .i_x     (w_cos),
        .o_angle (w_pitch)
    );

    q2e_cordic #(.P_ITER(CORDIC_ITERATIONS)) u_yaw (
        .i_clk   (i_clk),
        .i_y     (r_dly[DLY-1].num_y),
        .i_x     (r_dly[DLY-1].den_y),
        .o_angle (w_yaw)
    );

    // Limit to the angle ranges.
    logic signed [RND_W-1:0] n_roll, n_pitch, n_yaw;

    always_comb begin
        if (w_roll > LIM_PI) begin
            n_roll = LIM_PI;
        end else if (w_roll < -LIM_PI) begin
            n_roll = -LIM_PI;
        end else begin
            n_roll = w_roll;
        end
        if (w_pitch > LIM_HALFPI) begin
            n_pitch = LIM_HALFPI;
        end else if (w_pitch < -LIM_HALFPI) begin
            n_pitch = -LIM_HALFPI;
        end else begin
            n_pitch = w_pitch;
        end
        if (w_yaw > LIM_PI) begin
            n_yaw = LIM_PI;
        end else if (w_yaw < -LIM_PI) begin
            n_yaw = -LIM_PI;
        end else begin
            n_yaw = w_yaw;
        end
    end

    always_ff @(posedge i_clk) begin
        o_roll_angle  <= n_roll[ANG_W-1:0];
        o_pitch_angle <= n_pitch[PITCH_W-1:0];
        o_yaw_angle   <= n_yaw[ANG_W-1:0];
    end

    // A result beat always traces back to an accepted beat a fixed latency ago.
    a_valid_from_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_accept, LAT))
        else $error("result beat without a matching input beat");

    a_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> !busy)
        else $error("busy raised outside reset");

    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pitch_angle <= 15'sd12868 && o_pitch_angle >= -15'sd12868))
        else $error("pitch out of range");

    a_roll_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_roll_angle <= 16'sd25736 && o_roll_angle >= -16'sd25736))
        else $error("roll out of range");

endmodule

`default_nettype wire

>>> verif/q2e_angle_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q2e_angle_checker
// Watches the quaternion input beats and the angle result beats, predicts
// roll, pitch and yaw for every accepted quaternion and compares in order.
// ----------------------------------------------------------------------------
module q2e_angle_checker
    import q2e_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   start,
    input  wire logic                   busy,
    input  wire logic signed [IN_W-1:0] i_quat_w,
    input  wire logic signed [IN_W-1:0] i_quat_x,
    input  wire logic signed [IN_W-1:0] i_quat_y,
    input  wire logic signed [IN_W-1:0] i_quat_z,
    input  wire logic                   o_valid,
    input  wire logic signed [ANG_W-1:0]   o_roll_angle,
    input  wire logic signed [PITCH_W-1:0] o_pitch_angle,
    input  wire logic signed [ANG_W-1:0]   o_yaw_angle,
    output int                          o_mismatches,
    output int                          o_pending,
    output int                          o_results,
    output logic                        o_beat
);

    typedef struct packed {
        logic signed [ANG_W-1:0]   roll;
        logic signed [PITCH_W-1:0] pitch;
        logic signed [ANG_W-1:0]   yaw;
    } t_angles;

    t_angles angles_due[$];

    localparam longint ONE_FX  = 64'sd1 << 28;
    localparam longint PI_FX   = 64'sd3373259426;
    localparam longint NORM_FX = 64'sd1 << 40;

    function automatic longint abs_l(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint root_floor(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return longint'(res);
    endfunction

    // Vectoring CORDIC, angle in Q2.30.
    function automatic longint vector_angle(longint y, longint x);
        longint ang;
        longint dx;
        longint dy;
        int     n;
        ang = 0;
        n   = (CORDIC_ITERATIONS > TBL_N) ? TBL_N : CORDIC_ITERATIONS;
        if (y == 0) return (x < 0) ? PI_FX : 0;
        if (x < 0) begin
            ang = (y > 0) ? PI_FX : -PI_FX;
            x   = -x;
            y   = -y;
        end
        while (abs_l(x) < NORM_FX && abs_l(y) < NORM_FX) begin
            x = x * 2;
            y = y * 2;
        end
        for (int i = 0; i < n; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x   = x + dx;
                y   = y - dy;
                ang = ang + longint'(ATAN_TABLE[i]);
            end else begin
                x   = x - dx;
                y   = y + dy;
                ang = ang - longint'(ATAN_TABLE[i]);
            end
        end
        return ang;
    endfunction

    function automatic longint round_q13(longint a, longint lim);
        longint r;
        r = (a + (64'sd1 << 16)) >>> 17;
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r;
    endfunction

    function automatic t_angles euler_of(longint w, longint x, longint y, longint z);
        t_angles res;
        longint  s;
        longint  c;
        res.roll = ANG_W'(round_q13(vector_angle(2 * (w * x + y * z),
                                    ONE_FX - 2 * (x * x + y * y)), 25736));
        s = 2 * (w * y - z * x);
        if (s > ONE_FX) s = ONE_FX;
        if (s < -ONE_FX) s = -ONE_FX;
        c = root_floor((64'd1 << 56) - longint'(s * s));
        res.pitch = PITCH_W'(round_q13(vector_angle(s, c), 12868));
        res.yaw = ANG_W'(round_q13(vector_angle(2 * (w * z + x * y),
                                   ONE_FX - 2 * (y * y + z * z)), 25736));
        return res;
    endfunction

    assign o_pending = angles_due.size();
    assign o_beat    = i_rst_n && ((start && !busy) || o_valid);

    initial begin
        o_mismatches = 0;
        o_results    = 0;
    end

    always @(posedge i_clk) begin
        t_angles due;
        if (i_rst_n && start && !busy)
            angles_due.push_back(euler_of(i_quat_w, i_quat_x, i_quat_y, i_quat_z));
        if (i_rst_n && o_valid) begin
            o_results <= o_results + 1;
            if (angles_due.size() == 0) begin
                o_mismatches <= o_mismatches + 1;
                if (o_mismatches < 10)
                    $display("%0t: result beat with no quaternion pending", $time);
            end else begin
                due = angles_due.pop_front();
                if (due.roll !== o_roll_angle || due.pitch !== o_pitch_angle ||
                    due.yaw !== o_yaw_angle) begin
                    o_mismatches <= o_mismatches + 1;
                    if (o_mismatches < 10)
                        $display("%0t: angles exp r=%0d p=%0d y=%0d got r=%0d p=%0d y=%0d",
                                 $time, due.roll, due.pitch, due.yaw,
                                 o_roll_angle, o_pitch_angle, o_yaw_angle);
                end
            end
        end
    end

endmodule

>>> verif/quaternion_to_euler_angles_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_tb
// Drives directed and random quaternions with random input gaps and lets the
// checker compare every angle triple.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_tb;
    import q2e_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_BEATS   = 800;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [IN_W-1:0] i_quat_w = '0;
    logic signed [IN_W-1:0] i_quat_x = '0;
    logic signed [IN_W-1:0] i_quat_y = '0;
    logic signed [IN_W-1:0] i_quat_z = '0;
    logic o_valid;
    logic signed [ANG_W-1:0]   o_roll_angle;
    logic signed [PITCH_W-1:0] o_pitch_angle;
    logic signed [ANG_W-1:0]   o_yaw_angle;
    int   mismatches;
    int   pending;
    int   results;
    logic beat;
    int   quiet_cycles = 0;
    int   gap_pct = 0;
    int   sent = 0;

    always #5 i_clk = ~i_clk;

    quaternion_to_euler_angles u_dut (
        .i_clk, .i_rst_n, .start, .busy,
        .i_quat_w, .i_quat_x, .i_quat_y, .i_quat_z,
        .o_valid, .o_roll_angle, .o_pitch_angle, .o_yaw_angle
    );

    q2e_angle_checker u_checker (
        .i_clk, .i_rst_n, .start, .busy,
        .i_quat_w, .i_quat_x, .i_quat_y, .i_quat_z,
        .o_valid, .o_roll_angle, .o_pitch_angle, .o_yaw_angle,
        .o_mismatches(mismatches), .o_pending(pending),
        .o_results(results), .o_beat(beat)
    );

    always @(posedge i_clk) begin
        quiet_cycles <= beat ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired after %0d quiet cycles", quiet_cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Presents one quaternion and returns at the edge that takes it.
    // Each cycle before the beat is left idle with a chance of gap_pct percent.
    task automatic send_quat(int w, int x, int y, int z);
        while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start    <= 1'b1;
        i_quat_w <= IN_W'(w);
        i_quat_x <= IN_W'(x);
        i_quat_y <= IN_W'(y);
        i_quat_z <= IN_W'(z);
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        sent++;
    endtask

    function automatic int rand_comp();
        case ($urandom_range(9))
            0: return 16384;
            1: return -16384;
            2: return 0;
            default: return int'($urandom_range(32768)) - 16384;
        endcase
    endfunction

    // Random part in -scale..scale; one component draws from a larger range than the others.
    function automatic int rand_part(int scale);
        return (int'($urandom_range(2 * scale)) - scale);
    endfunction

    initial begin
        int q[4];
        int big;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Axes, signs, clamped arcsine, atan2 of a zero vector and the pi axis.
        send_quat(16384, 0, 0, 0);
        send_quat(0, 16384, 0, 0);
        send_quat(0, 0, 16384, 0);
        send_quat(0, 0, 0, 16384);
        send_quat(-16384, 0, 0, 0);
        send_quat(0, -16384, 0, 0);
        send_quat(0, 8192, 8192, 0);
        send_quat(0, 0, 8192, 8192);
        send_quat(16384, 0, 16384, 0);
        send_quat(16384, 0, -16384, 0);
        send_quat(16384, 16384, 16384, 16384);
        send_quat(-16384, -16384, -16384, -16384);
        send_quat(8192, 16384, 0, 0);
        send_quat(-8192, 16384, 0, 0);
        send_quat(11585, 0, 0, 11585);
        send_quat(0, 0, 0, 0);
        send_quat(8192, 8192, 8192, 8192);
        send_quat(16384, -16384, 16384, -16384);

        for (int n = 0; n < RANDOM_BEATS; n++) begin
            gap_pct = (n < RANDOM_BEATS / 3) ? 28 : (n < 2 * RANDOM_BEATS / 3) ? 67 : 0;
            if ($urandom_range(3) == 0) begin
                for (int k = 0; k < 4; k++) q[k] = rand_comp();
            end else begin
                big = $urandom_range(3);
                for (int k = 0; k < 4; k++)
                    q[k] = (k == big) ? rand_part(16384) : rand_part(9000);
            end
            send_quat(q[0], q[1], q[2], q[3]);
        end
        start <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (CORDIC_ITER_GUARD()) @(posedge i_clk);

        $display("Sent %0d quaternions (axes, clamps, zero vectors, random), %0d angle beats",
                 sent, results);
        $display("checked, %0d mismatches, %0d still pending", mismatches, pending);
        if (mismatches == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    function automatic int CORDIC_ITER_GUARD();
        return 16 + 40 + 20;
    endfunction

endmodule

>>> sim.f
src/q2e_pkg.sv
src/q2e_sqrt.sv
src/q2e_cordic.sv
src/quaternion_to_euler_angles.sv
verif/q2e_angle_checker.sv
verif/quaternion_to_euler_angles_tb.sv
